// ----- src/jse_pkg.sv -----
// Shared types, character constants and token helpers of the JSON string escaper.
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

    localparam int NUM_TOK = 5;
    localparam int TOK_IDX_W = $clog2(NUM_TOK);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_HEX_AF = 8'h57;  // 'a' - 10

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_CR = 8'h0D;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] SURR_HI   = 16'hD800;
    localparam logic [15:0] SURR_LO   = 16'hDC00;

    // Output token: a quote or plain byte, a two-byte escape, or a \uXXXX escape.
    typedef enum logic [1:0] {
        TOK_NONE,
        TOK_RAW,
        TOK_ESC,
        TOK_U16
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] val;
    } token_t;

    typedef token_t [NUM_TOK-1:0] tok_list_t;

    // Partial UTF-8 sequence carried between input bytes.
    typedef struct packed {
        logic [7:0] pend0;
        logic [7:0] pend1;
        logic [7:0] pend2;
        logic [1:0] cnt;
        logic [2:0] seq_len;
    } seq_state_t;

    function automatic token_t make_tok(tok_kind_t kind, logic [15:0] val);
        token_t t;
        t.kind = kind;
        t.val  = val;
        return t;
    endfunction

    function automatic token_t u16_tok(logic [15:0] val);
        return make_tok(TOK_U16, val);
    endfunction

    function automatic token_t ascii_tok(logic [7:0] c);
        token_t t;
        case (c)
            CH_QUOTE:  t = make_tok(TOK_ESC, {8'h00, CH_QUOTE});
            CH_BSLASH: t = make_tok(TOK_ESC, {8'h00, CH_BSLASH});
            CTL_BS:    t = make_tok(TOK_ESC, {8'h00, CH_LOWER_B});
            CTL_FF:    t = make_tok(TOK_ESC, {8'h00, CH_LOWER_F});
            CTL_LF:    t = make_tok(TOK_ESC, {8'h00, CH_LOWER_N});
            CTL_CR:    t = make_tok(TOK_ESC, {8'h00, CH_LOWER_R});
            CTL_HT:    t = make_tok(TOK_ESC, {8'h00, CH_LOWER_T});
            default:
            begin
                if (c[7:5] == 3'b000)
                    t = u16_tok({8'h00, c});
                else
                    t = make_tok(TOK_RAW, {8'h00, c});
            end
        endcase
        return t;
    endfunction

    // Byte of a truncated tail, always in escape mode.
    function automatic token_t tail_tok(logic [7:0] c);
        return c[7] ? u16_tok({8'h00, c}) : ascii_tok(c);
    endfunction

    function automatic logic [2:0] lead_length(logic [7:0] c);
        logic [2:0] len;
        if (c[7:5] == 3'b110)
            len = 3'd2;
        else if (c[7:4] == 4'b1110)
            len = 3'd3;
        else if (c[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        return (d < 4'd10) ? (CH_ZERO + {4'h0, d}) : (CH_HEX_AF + {4'h0, d});
    endfunction

    function automatic logic [2:0] tok_len(token_t t);
        logic [2:0] len;
        case (t.kind)
            TOK_RAW: len = 3'd1;
            TOK_ESC: len = 3'd2;
            TOK_U16: len = 3'd6;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tok_byte(token_t t, logic [2:0] pos);
        logic [7:0] b;
        case (t.kind)
            TOK_RAW: b = t.val[7:0];
            TOK_ESC: b = (pos == 3'd0) ? CH_BSLASH : t.val[7:0];
            TOK_U16:
            begin
                case (pos)
                    3'd0:    b = CH_BSLASH;
                    3'd1:    b = CH_LOWER_U;
                    3'd2:    b = hex_char(t.val[15:12]);
                    3'd3:    b = hex_char(t.val[11:8]);
                    3'd4:    b = hex_char(t.val[7:4]);
                    default: b = hex_char(t.val[3:0]);
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/json_string_escaper.sv -----
// Top level of the JSON string escaper: input register, sequence state and result emitter.
`timescale 1ns / 1ps
`default_nettype none

// Takes the bytes of a string on the slave stream (tuser marks the first byte, tlast
// the last) and sends its quoted, escaped JSON text on the master stream, one byte per
// cycle while m_axis_tready is high, with tlast on the final byte caused by each input
// byte. An input byte causes 1 to 19 output bytes (a byte that only extends a UTF-8
// sequence sends nothing), so plain ASCII runs at one byte per cycle while the output
// is ready. The output port is the limit: escapes of 2, 6 or 12 bytes hold off the
// input. A request passes the input register, then the result register, before its first
// byte goes out. escape_non_ascii is written via cfg_wr_en/cfg_wr_data; the user must
// do so only while the block is idle (not enforced); reset value 0 (raw passthrough).

module json_string_escaper (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,    // escape_non_ascii
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte
    input  wire logic       s_axis_tuser,   // first_of_string
    input  wire logic       s_axis_tlast,   // last_of_string
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_char
    output logic            m_axis_tlast    // last_of_run
);

    logic                 esc_reg;
    logic                 in_vld_reg;
    logic [7:0]           in_data_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;
    jse_pkg::seq_state_t  st_reg;
    jse_pkg::seq_state_t  st_next;
    jse_pkg::tok_list_t   toks;
    logic                 emit_free;
    logic                 take;

    assign take          = in_vld_reg && emit_free;
    assign s_axis_tready = !in_vld_reg || emit_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            in_vld_reg <= 1'b0;
            st_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                esc_reg <= cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                in_vld_reg <= 1'b1;
            else if (take)
                in_vld_reg <= 1'b0;
            if (take)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    jse_encoder u_encoder (
        .data_byte        (in_data_reg),
        .first_of_string  (in_first_reg),
        .last_of_string   (in_last_reg),
        .escape_non_ascii (esc_reg),
        .st               (st_reg),
        .st_next          (st_next),
        .toks             (toks)
    );

    jse_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take),
        .toks          (toks),
        .free          (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- src/jse_encoder.sv -----
// Per-byte escape decision: turns one input byte and the pending sequence into tokens.
`timescale 1ns / 1ps
`default_nettype none

module jse_encoder (
    input  wire logic [7:0]          data_byte,
    input  wire logic                first_of_string,
    input  wire logic                last_of_string,
    input  wire logic                escape_non_ascii,
    input  jse_pkg::seq_state_t      st,
    output jse_pkg::seq_state_t      st_next,
    output jse_pkg::tok_list_t       toks
);

    logic [1:0]  cnt;
    logic [2:0]  seq_len;
    logic [2:0]  n_run;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic [2:0]  len_c;

    always_comb
    begin
        cnt     = first_of_string ? 2'd0 : st.cnt;
        seq_len = first_of_string ? 3'd0 : st.seq_len;
        n_run   = {1'b0, cnt} + 3'd1;
        len_c   = jse_pkg::lead_length(data_byte);

        case (seq_len)
            3'd2:    cp = {10'h000, st.pend0[4:0], data_byte[5:0]};
            3'd3:    cp = {5'h00, st.pend0[3:0], st.pend1[5:0], data_byte[5:0]};
            default: cp = {st.pend0[2:0], st.pend1[5:0], st.pend2[5:0], data_byte[5:0]};
        endcase
        cp_off = cp - jse_pkg::SUPP_BASE;

        st_next         = st;
        st_next.cnt     = cnt;
        st_next.seq_len = seq_len;

        for (int i = 0; i < jse_pkg::NUM_TOK; i++)
            toks[i] = jse_pkg::make_tok(jse_pkg::TOK_NONE, 16'h0000);

        if (first_of_string)
            toks[0] = jse_pkg::make_tok(jse_pkg::TOK_RAW, {8'h00, jse_pkg::CH_QUOTE});
        if (last_of_string)
            toks[4] = jse_pkg::make_tok(jse_pkg::TOK_RAW, {8'h00, jse_pkg::CH_QUOTE});

        if (cnt != 2'd0)
        begin
            if (n_run >= seq_len)
            begin
                // sequence complete
                if (cp[20:16] != 5'd0)
                begin
                    toks[1] = jse_pkg::u16_tok(jse_pkg::SURR_HI | {6'd0, cp_off[19:10]});
                    toks[2] = jse_pkg::u16_tok(jse_pkg::SURR_LO | {6'd0, cp_off[9:0]});
                end
                else
                begin
                    toks[1] = jse_pkg::u16_tok(cp[15:0]);
                end
                st_next.cnt     = 2'd0;
                st_next.seq_len = 3'd0;
            end
            else if (last_of_string)
            begin
                // truncated: lead escaped, trailing bytes redone
                toks[1] = jse_pkg::u16_tok({8'h00, st.pend0});
                if (cnt == 2'd1)
                begin
                    toks[2] = jse_pkg::tail_tok(data_byte);
                end
                else if (jse_pkg::lead_length(st.pend1) == 3'd2)
                begin
                    toks[2] = jse_pkg::u16_tok({5'd0, st.pend1[4:0], data_byte[5:0]});
                end
                else
                begin
                    toks[2] = jse_pkg::tail_tok(st.pend1);
                    toks[3] = jse_pkg::tail_tok(data_byte);
                end
                st_next.cnt     = 2'd0;
                st_next.seq_len = 3'd0;
            end
            else if (cnt != 2'd3)
            begin
                case (cnt)
                    2'd1:    st_next.pend1 = data_byte;
                    default: st_next.pend2 = data_byte;
                endcase
                st_next.cnt = cnt + 2'd1;
            end
        end
        else if (!data_byte[7] || !escape_non_ascii)
        begin
            toks[1] = jse_pkg::ascii_tok(data_byte);
        end
        else if (last_of_string || len_c == 3'd0)
        begin
            toks[1] = jse_pkg::u16_tok({8'h00, data_byte});
        end
        else
        begin
            st_next.pend0   = data_byte;
            st_next.cnt     = 2'd1;
            st_next.seq_len = len_c;
        end
    end

endmodule

`default_nettype wire

// ----- src/jse_emitter.sv -----
// Result register: holds one request's tokens; sends one byte per cycle while ready.
`timescale 1ns / 1ps
`default_nettype none

module jse_emitter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  jse_pkg::tok_list_t       toks,
    output logic                     free,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,   // out_char
    output logic                     m_axis_tlast    // last_of_run
);

    jse_pkg::tok_list_t             tok_reg;
    logic [jse_pkg::NUM_TOK-1:0]    vld_reg;
    logic [jse_pkg::NUM_TOK-1:0]    vld_next;
    logic [2:0]                     pos_reg;
    logic [2:0]                     pos_next;
    logic [jse_pkg::TOK_IDX_W-1:0]  idx;
    jse_pkg::token_t                cur;
    logic                           tok_end;
    logic                           only_tok;
    logic [jse_pkg::NUM_TOK-1:0]    others;

    always_comb
    begin
        idx = '0;
        for (int i = jse_pkg::NUM_TOK - 1; i >= 0; i--)
            if (vld_reg[i])
                idx = jse_pkg::TOK_IDX_W'(i);
        cur    = tok_reg[idx];
        others = vld_reg;
        others[idx] = 1'b0;
        tok_end  = (pos_reg == jse_pkg::tok_len(cur) - 3'd1);
        only_tok = (others == '0);

        m_axis_tvalid = |vld_reg;
        m_axis_tdata  = jse_pkg::tok_byte(cur, pos_reg);
        m_axis_tlast  = tok_end && only_tok;
        free = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);

        vld_next = vld_reg;
        pos_next = pos_reg;
        if (load)
        begin
            for (int i = 0; i < jse_pkg::NUM_TOK; i++)
                vld_next[i] = (toks[i].kind != jse_pkg::TOK_NONE);
            pos_next = 3'd0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (tok_end)
            begin
                vld_next = others;
                pos_next = 3'd0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            pos_reg <= 3'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            tok_reg <= toks;
    end

endmodule

`default_nettype wire

// ----- sim/tb_json_string_escaper.sv -----
// Self-checking testbench of the JSON string escaper: stream stimulus, prediction and output check.
`timescale 1ns / 1ps

module tb_json_string_escaper;

    import jse_pkg::*;

    localparam int         CLK_HALF     = 5;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         LONG_HOLD    = 300;
    localparam int         HOLD_AFTER   = 80;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] NON_ASCII    = 8'h80;
    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } str_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last_of_run;
    } json_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // data_byte
    logic       s_axis_tuser = 1'b0;    // first_of_string
    logic       s_axis_tlast = 1'b0;    // last_of_string
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // out_char
    logic       m_axis_tlast;           // last_of_run

    str_req_t   pending_reqs[$];
    json_char_t expected_chars[$];

    // predictor state
    logic        esc_mode = 1'b0;
    logic [23:0] utf8_pend = '0;
    int          utf8_cnt = 0;
    int          utf8_seq_len = 0;

    // driver / receiver state
    bit          req_taken = 1'b0;
    str_req_t    nxt_req;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [15:0] rdy_pattern = 16'hFFFF;
    logic [3:0]  rdy_pos = 4'd0;

    int          errors = 0;
    int          reqs_queued = 0;
    int          reqs_accepted = 0;
    int          chars_checked = 0;
    int          strings_sent = 0;
    int          phases_run = 0;
    json_char_t  want;

    json_string_escaper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout after %0d requests and %0d output bytes", reqs_accepted, chars_checked);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // ---------------- escaped-text predictor ----------------

    function automatic logic [7:0] hex_digit(logic [3:0] n);
        return HEX_DIGITS[8*(15-n) +: 8];
    endfunction

    function automatic void emit(logic [7:0] ch);
        json_char_t e;
        e.ch = ch;
        e.last_of_run = 1'b0;
        expected_chars.insert(expected_chars.size(), e);
    endfunction

    function automatic void emit_u16(logic [15:0] v);
        emit(CH_BSLASH);
        emit(CH_LOWER_U);
        emit(hex_digit(v[15:12]));
        emit(hex_digit(v[11:8]));
        emit(hex_digit(v[7:4]));
        emit(hex_digit(v[3:0]));
    endfunction

    function automatic void emit_plain(logic [7:0] c);
        if (c == CH_QUOTE || c == CH_BSLASH)
        begin
            emit(CH_BSLASH);
            emit(c);
        end
        else if (c < ASCII_SPACE)
        begin
            case (c)
                CTL_BS:  begin emit(CH_BSLASH); emit(CH_LOWER_B); end
                CTL_FF:  begin emit(CH_BSLASH); emit(CH_LOWER_F); end
                CTL_LF:  begin emit(CH_BSLASH); emit(CH_LOWER_N); end
                CTL_CR:  begin emit(CH_BSLASH); emit(CH_LOWER_R); end
                CTL_HT:  begin emit(CH_BSLASH); emit(CH_LOWER_T); end
                default: emit_u16({8'h00, c});
            endcase
        end
        else
            emit(c);
    endfunction

    function automatic int utf8_len(logic [7:0] c);
        if ((c & 8'hE0) == 8'hC0)
            return 2;
        if ((c & 8'hF0) == 8'hE0)
            return 3;
        if ((c & 8'hF8) == 8'hF0)
            return 4;
        return 0;
    endfunction

    // seq holds the lead in its low byte, continuations above
    function automatic void emit_codepoint(logic [31:0] seq, int n);
        logic [31:0] cp;
        int k;
        case (n)
            2:       cp = {27'd0, seq[4:0]};
            3:       cp = {28'd0, seq[3:0]};
            default: cp = {29'd0, seq[2:0]};
        endcase
        for (k = 1; k < n; k++)
            cp = (cp << 6) | {26'd0, seq[8*k +: 6]};
        if (cp >= 32'h10000)
        begin
            cp = cp - 32'h10000;
            emit_u16(SURR_HI + {6'd0, cp[19:10]});
            emit_u16(SURR_LO + {6'd0, cp[9:0]});
        end
        else
            emit_u16(cp[15:0]);
    endfunction

    // bytes known to end the string, always in escape mode
    function automatic void emit_tail(logic [31:0] seq, int n);
        int i;
        int len;
        logic [7:0] c;
        i = 0;
        while (i < n)
        begin
            c = seq[8*i +: 8];
            len = utf8_len(c);
            if (c < NON_ASCII)
            begin
                emit_plain(c);
                i++;
            end
            else if (len != 0 && i + len <= n)
            begin
                emit_codepoint(seq >> (8*i), len);
                i += len;
            end
            else
            begin
                emit_u16({8'h00, c});
                i++;
            end
        end
    endfunction

    function automatic void escape_byte(logic [7:0] c, logic first, logic last);
        int base;
        int cnt;
        logic [31:0] run;
        base = expected_chars.size();
        if (first)
        begin
            utf8_cnt = 0;
            utf8_seq_len = 0;
            emit(CH_QUOTE);
        end
        cnt = utf8_cnt;
        if (cnt > 0)
        begin
            run = {8'h00, utf8_pend};
            run[8*cnt +: 8] = c;
            if (cnt + 1 >= utf8_seq_len)
            begin
                emit_codepoint(run, utf8_seq_len);
                utf8_cnt = 0;
                utf8_seq_len = 0;
            end
            else if (last)
            begin
                emit_tail(run, cnt + 1);
                utf8_cnt = 0;
                utf8_seq_len = 0;
            end
            else if (cnt < 3)
            begin
                utf8_pend[8*cnt +: 8] = c;
                utf8_cnt = cnt + 1;
            end
        end
        else if (c < NON_ASCII || !esc_mode)
            emit_plain(c);
        else if (last || utf8_len(c) == 0)
            emit_u16({8'h00, c});   // invalid lead, or lead cut off by end of string
        else
        begin
            utf8_pend[7:0] = c;
            utf8_cnt = 1;
            utf8_seq_len = utf8_len(c);
        end
        if (last)
            emit(CH_QUOTE);
        if (expected_chars.size() > base)
            expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------- sender ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || req_taken)
        begin
            req_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                nxt_req = pending_reqs.pop_front();
                s_axis_tdata  <= nxt_req.data;
                s_axis_tuser  <= nxt_req.first;
                s_axis_tlast  <= nxt_req.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && reqs_accepted >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= rdy_pattern[rdy_pos];
            rdy_pos = rdy_pos + 4'd1;
            if (rdy_pos == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       rdy_pattern = 16'hFFFF;
                    1:       rdy_pattern = 16'($urandom | $urandom);
                    2:       rdy_pattern = 16'($urandom);
                    default: rdy_pattern = 16'($urandom & $urandom) | 16'h0001;
                endcase
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                esc_mode = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                escape_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
                req_taken = 1'b1;
                reqs_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                              m_axis_tdata, m_axis_tlast));
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch)
                        report_mismatch($sformatf("out_char %02h, expected %02h",
                                                  m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b (char %02h)",
                                                  m_axis_tlast, want.last_of_run, want.ch));
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_req(input logic [7:0] data, input logic first, input logic last);
        str_req_t r;
        r.data  = data;
        r.first = first;
        r.last  = last;
        pending_reqs.insert(pending_reqs.size(), r);
        reqs_queued++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        phases_run++;
    endtask

    task automatic queue_lead(input int n, input int conts, inout logic [7:0] body[$]);
        logic [31:0] rnd;
        int k;
        rnd = $urandom;
        case (n)
            2:       body.insert(body.size(), {3'b110, rnd[4:0]});
            3:       body.insert(body.size(), {4'b1110, rnd[3:0]});
            default: body.insert(body.size(), {5'b11110, rnd[2:0]});
        endcase
        for (k = 0; k < conts; k++)
            body.insert(body.size(), {2'b10, rnd[8+6*k +: 6]});
    endtask

    task automatic queue_random_string();
        logic [7:0] body[$];
        int units;
        int k;
        int n;
        int shape;
        body = {};
        units = $urandom_range(1, 10);
        for (k = 0; k < units; k++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: body.insert(body.size(), 8'($urandom_range(8'h20, 8'h7E)));
                4:
                begin
                    case ($urandom_range(0, 6))
                        0:       body.insert(body.size(), CH_QUOTE);
                        1:       body.insert(body.size(), CH_BSLASH);
                        2:       body.insert(body.size(), CTL_BS);
                        3:       body.insert(body.size(), CTL_FF);
                        4:       body.insert(body.size(), CTL_LF);
                        5:       body.insert(body.size(), CTL_CR);
                        default: body.insert(body.size(), CTL_HT);
                    endcase
                end
                5:  body.insert(body.size(), 8'($urandom_range(8'h00, 8'h1F)));
                6:  queue_lead(2, 1, body);
                7:  queue_lead(3, 2, body);
                8:  queue_lead(4, 3, body);
                9:  body.insert(body.size(),
                                8'(($urandom_range(0, 1) == 0) ? $urandom_range(8'h80, 8'hBF)
                                                               : $urandom_range(8'hF8, 8'hFF)));
                10:
                begin
                    n = $urandom_range(2, 4);
                    queue_lead(n, $urandom_range(0, n - 2), body);
                end
                default: body.insert(body.size(), 8'($urandom_range(0, 255)));
            endcase
        end
        // mostly well-formed marks; a few strings lose their opening or closing mark
        shape = $urandom_range(0, 19);
        for (k = 0; k < body.size(); k++)
            queue_req(body[k], (k == 0) && (shape != 0), (k == body.size() - 1) && (shape != 1));
        strings_sent++;
    endtask

    task automatic queue_noise();
        int n;
        int k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic run_random_phase(input logic mode, input int target);
        int start;
        write_mode(mode);
        start = reqs_queued;
        while (reqs_queued - start < target)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_noise();
            else
                queue_random_string();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw mode: every escape class, extremes of the byte range
        write_mode(1'b0);
        queue_req(CH_QUOTE, 1'b1, 1'b0);
        queue_req(CH_BSLASH, 1'b0, 1'b0);
        queue_req(CTL_BS, 1'b0, 1'b0);
        queue_req(CTL_FF, 1'b0, 1'b0);
        queue_req(CTL_LF, 1'b0, 1'b0);
        queue_req(CTL_CR, 1'b0, 1'b0);
        queue_req(CTL_HT, 1'b0, 1'b0);
        queue_req(8'h00, 1'b0, 1'b0);
        queue_req(8'h7F, 1'b0, 1'b0);
        queue_req(8'h80, 1'b0, 1'b0);
        queue_req(8'hFF, 1'b0, 1'b1);
        strings_sent++;
        drain();

        // escape mode: 2/3/4-byte sequences, surrogate pair, invalid lead, truncated tail
        write_mode(1'b1);
        queue_req(8'hC3, 1'b1, 1'b0);
        queue_req(8'hA9, 1'b0, 1'b0);
        queue_req(8'hE2, 1'b0, 1'b0);
        queue_req(8'h82, 1'b0, 1'b0);
        queue_req(8'hAC, 1'b0, 1'b0);
        queue_req(8'hF0, 1'b0, 1'b0);
        queue_req(8'h9F, 1'b0, 1'b0);
        queue_req(8'h98, 1'b0, 1'b0);
        queue_req(8'h80, 1'b0, 1'b0);
        queue_req(8'h80, 1'b0, 1'b0);
        queue_req(8'hF0, 1'b0, 1'b0);
        queue_req(8'h41, 1'b0, 1'b1);
        // pending lead dropped by a new string, then a lead that is the last byte
        queue_req(8'hC3, 1'b1, 1'b0);
        queue_req(8'hE5, 1'b1, 1'b1);
        // lead left pending across a mode change
        queue_req(8'hE2, 1'b1, 1'b0);
        strings_sent += 3;
        drain();
        write_mode(1'b0);
        queue_req(8'h82, 1'b0, 1'b0);
        queue_req(8'hAC, 1'b0, 1'b1);
        drain();

        run_random_phase(1'b1, 60);
        run_random_phase(1'b0, 60);
        run_random_phase(1'b1, 60);
        run_random_phase(1'b1, 60);
        run_random_phase(1'b0, 60);
        run_random_phase(1'b1, 60);

        repeat (20) @(posedge clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d expected output bytes never arrived",
                                      expected_chars.size()));

        $display("Run: %0d strings, %0d requests, %0d output bytes checked, %0d mode writes",
                 strings_sent, reqs_accepted, chars_checked, phases_run);
        $display("Both escape settings, truncated and dropped sequences, long output stall");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
